@@ design/edmm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edmm_pkg
// Shared sizes, table byte layout, register indexes and types of the event
// decision matrix matcher.
// ----------------------------------------------------------------------------
package edmm_pkg;

	localparam int ROWS       = 8;
	localparam int ROW_BYTES  = 8;
	localparam int TABLE_SIZE = ROWS * ROW_BYTES;
	localparam int MAX_OUT    = 8;

	localparam int ADDR_W     = 6;
	localparam int BSEL_W     = 3;
	localparam int ROW_CNT_W  = $clog2(ROWS + 1);
	localparam int OUT_CNT_W  = $clog2(MAX_OUT + 1);
	localparam int CFG_IDX_W  = 2;

	// byte positions within one row
	localparam logic [BSEL_W-1:0] BYTE_ORIGIN = 3'd0;
	localparam logic [BSEL_W-1:0] BYTE_FLAGS  = 3'd1;
	localparam logic [BSEL_W-1:0] BYTE_CMASK  = 3'd2;
	localparam logic [BSEL_W-1:0] BYTE_CFILT  = 3'd3;
	localparam logic [BSEL_W-1:0] BYTE_TMASK  = 3'd4;
	localparam logic [BSEL_W-1:0] BYTE_TFILT  = 3'd5;
	localparam logic [BSEL_W-1:0] BYTE_ACTION = 3'd6;

	// flag byte bit positions
	localparam int FLAG_ENABLED = 7;
	localparam int FLAG_ORIGIN  = 6;
	localparam int FLAG_ZONE    = 4;
	localparam int FLAG_SUBZONE = 3;
	localparam int FLAG_MASK_B8 = 1;
	localparam int FLAG_FILT_B8 = 0;

	localparam logic [8:0] PROTOCOL_CLASS = 9'd0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NODE_ZONE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_SUBZONE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACT_ONE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACT_TWO      = 2'd3;

	localparam logic [7:0] ACT_ONE_RESET = 8'd1;
	localparam logic [7:0] ACT_TWO_RESET = 8'd2;

	// operations
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVENT = 1'b1;

	// action select codes
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_ONE  = 2'd1;
	localparam logic [1:0] ACT_TWO  = 2'd2;

	typedef struct packed {
		logic [8:0] ev_class;
		logic [7:0] ev_type;
		logic [7:0] origin;
		logic [7:0] zone;
		logic [7:0] subzone;
	} event_t;

	typedef struct packed {
		logic [7:0] node_zone;
		logic [7:0] node_subzone;
		logic [7:0] act_one;
		logic [7:0] act_two;
	} cfg_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] act;
	} hit_t;

endpackage

@@ design/edmm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edmm_cell
// One table row: holds its eight bytes, checks the held event against them
// while the walk token sits here, and hands the token to the next cell.
// ----------------------------------------------------------------------------
module edmm_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [edmm_pkg::BSEL_W-1:0] wr_sel,
	input  logic [7:0]                  wr_data,
	input  edmm_pkg::event_t            ev,
	input  edmm_pkg::cfg_t              cfg,
	input  logic                        shift,
	input  logic                        tok_in,
	output logic                        tok_q,
	output edmm_pkg::hit_t              hit
);

	logic [7:0] row_q [edmm_pkg::ROW_BYTES];
	logic [7:0] flags;
	logic [8:0] cmask;
	logic [8:0] cfilt;
	logic       match;
	logic [1:0] act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < edmm_pkg::ROW_BYTES; b++) begin
				row_q[b] <= 8'd0;
			end
		end else if (wr_en) begin
			row_q[wr_sel] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (shift) begin
			tok_q <= tok_in;
		end
	end

	always_comb begin
		flags = row_q[edmm_pkg::BYTE_FLAGS];
		cmask = {flags[edmm_pkg::FLAG_MASK_B8], row_q[edmm_pkg::BYTE_CMASK]};
		cfilt = {flags[edmm_pkg::FLAG_FILT_B8], row_q[edmm_pkg::BYTE_CFILT]};
		match = flags[edmm_pkg::FLAG_ENABLED]
			&& (ev.ev_class != edmm_pkg::PROTOCOL_CLASS)
			&& (!flags[edmm_pkg::FLAG_ORIGIN] || (ev.origin == row_q[edmm_pkg::BYTE_ORIGIN]))
			&& (!flags[edmm_pkg::FLAG_ZONE] || (ev.zone == cfg.node_zone))
			&& (!flags[edmm_pkg::FLAG_SUBZONE] || (ev.subzone == cfg.node_subzone))
			&& (((cfilt ^ ev.ev_class) & cmask) == 9'd0)
			&& (((row_q[edmm_pkg::BYTE_TFILT] ^ ev.ev_type)
				& row_q[edmm_pkg::BYTE_TMASK]) == 8'd0);
		// first code wins when both codes are equal
		if (row_q[edmm_pkg::BYTE_ACTION] == cfg.act_one) begin
			act = edmm_pkg::ACT_ONE;
		end else if (row_q[edmm_pkg::BYTE_ACTION] == cfg.act_two) begin
			act = edmm_pkg::ACT_TWO;
		end else begin
			act = edmm_pkg::ACT_NONE;
		end
		hit.hit = tok_q && match && (act != edmm_pkg::ACT_NONE);
		hit.act = hit.hit ? act : edmm_pkg::ACT_NONE;
	end

endmodule

@@ design/event_decision_matrix_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_decision_matrix_matcher
// Decision table matcher: a row of table cells walked by a token, one row
// per cycle, with a pending-result stage and an output register.
// ----------------------------------------------------------------------------
// A table write returns one result with the byte read back. An event
// runs from transfer to the next free input slot in order: a start, then
// the match token steps from cell to cell through each table row, then a
// close with the final result. Only a stalled output can hold the walk or
// the close. Each matching row with a known action gives one result, the
// last one flagged; an event with no such row gives a single empty result.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module event_decision_matrix_matcher (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [edmm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [edmm_pkg::ADDR_W-1:0]    table_address,
	input  logic [7:0]                     write_data,
	input  logic [8:0]                     event_class,
	input  logic [7:0]                     event_type,
	input  logic [7:0]                     origin_address,
	input  logic [7:0]                     event_zone,
	input  logic [7:0]                     event_subzone,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     row_index,
	output logic [1:0]                     action_select,
	output logic [7:0]                     readback_data,
	output logic                           last_result
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_FINAL = 3'b100
	} state_t;

	state_t                             st_q;
	edmm_pkg::cfg_t                     cfg_q;
	edmm_pkg::event_t                   ev_q;
	logic [edmm_pkg::ROWS-1:0]          tok;
	logic [edmm_pkg::ROWS-1:0]          tok_in;
	edmm_pkg::hit_t                     hit [edmm_pkg::ROWS];
	logic                               sel_hit;
	logic [1:0]                         sel_act;
	logic [edmm_pkg::ROW_CNT_W-1:0]     r_q;
	logic [edmm_pkg::ROW_CNT_W+2:0]     r_ext;
	logic [edmm_pkg::OUT_CNT_W-1:0]     cnt_q;
	logic                               pend_v_q;
	logic [2:0]                         pend_row_q;
	logic [1:0]                         pend_act_q;
	logic                               out_valid_q;
	logic [2:0]                         row_index_q;
	logic [1:0]                         action_select_q;
	logic [7:0]                         readback_data_q;
	logic                               last_result_q;
	logic                               out_free;
	logic                               acc;
	logic                               wr_fire;
	logic                               start;
	logic                               in_range;
	logic [edmm_pkg::ROW_CNT_W-1:0]     wr_row;
	logic                               hit_eff;
	logic                               advance;
	logic                               shift;
	logic                               walk_done;
	logic                               final_fire;
	logic                               push_pend;

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (st_q == ST_IDLE) && out_free;
	assign acc        = in_valid && in_ready;
	assign wr_fire    = acc && (operation == edmm_pkg::OP_WRITE);
	assign start      = acc && (operation == edmm_pkg::OP_EVENT);
	assign in_range   = 32'(table_address) < 32'(edmm_pkg::TABLE_SIZE);
	assign wr_row     = edmm_pkg::ROW_CNT_W'(table_address[edmm_pkg::ADDR_W-1:edmm_pkg::BSEL_W]);
	assign hit_eff    = sel_hit && (cnt_q < edmm_pkg::OUT_CNT_W'(edmm_pkg::MAX_OUT));
	assign advance    = (st_q == ST_WALK) && (!hit_eff || !pend_v_q || out_free);
	assign shift      = start || advance;
	assign walk_done  = advance && tok[edmm_pkg::ROWS-1];
	assign final_fire = (st_q == ST_FINAL) && out_free;
	assign push_pend  = advance && hit_eff && pend_v_q;
	assign r_ext      = {3'b000, r_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_zone    <= 8'd0;
			cfg_q.node_subzone <= 8'd0;
			cfg_q.act_one      <= edmm_pkg::ACT_ONE_RESET;
			cfg_q.act_two      <= edmm_pkg::ACT_TWO_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				edmm_pkg::REG_NODE_ZONE:    cfg_q.node_zone    <= cfg_data;
				edmm_pkg::REG_NODE_SUBZONE: cfg_q.node_subzone <= cfg_data;
				edmm_pkg::REG_ACT_ONE:      cfg_q.act_one      <= cfg_data;
				edmm_pkg::REG_ACT_TWO:      cfg_q.act_two      <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold the event for the whole walk
	always_ff @(posedge clk) begin
		if (start) begin
			ev_q.ev_class <= event_class;
			ev_q.ev_type  <= event_type;
			ev_q.origin   <= origin_address;
			ev_q.zone     <= event_zone;
			ev_q.subzone  <= event_subzone;
		end
	end

	for (genvar i = 0; i < edmm_pkg::ROWS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign tok_in[i] = start;
		end else begin : g_link
			assign tok_in[i] = tok[i-1];
		end

		edmm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_fire && in_range && (wr_row == edmm_pkg::ROW_CNT_W'(i))),
			.wr_sel  (table_address[edmm_pkg::BSEL_W-1:0]),
			.wr_data (write_data),
			.ev      (ev_q),
			.cfg     (cfg_q),
			.shift   (shift),
			.tok_in  (tok_in[i]),
			.tok_q   (tok[i]),
			.hit     (hit[i])
		);
	end

	// only the token cell reports, so a plain OR picks its answer
	always_comb begin
		sel_hit = 1'b0;
		sel_act = edmm_pkg::ACT_NONE;
		for (int i = 0; i < edmm_pkg::ROWS; i++) begin
			sel_hit = sel_hit | hit[i].hit;
			sel_act = sel_act | hit[i].act;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			r_q         <= '0;
			cnt_q       <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						st_q  <= ST_WALK;
						r_q   <= '0;
						cnt_q <= '0;
					end
				end
				ST_WALK: begin
					if (advance) begin
						r_q <= r_q + 1'b1;
						if (hit_eff) begin
							pend_v_q <= 1'b1;
							cnt_q    <= cnt_q + 1'b1;
						end
					end
					if (walk_done) begin
						st_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (final_fire) begin
						st_q     <= ST_IDLE;
						pend_v_q <= 1'b0;
					end
				end
				default: st_q <= ST_IDLE;
			endcase

			if (wr_fire || push_pend || final_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pending result and output payload
	always_ff @(posedge clk) begin
		if (advance && hit_eff) begin
			pend_row_q <= r_ext[2:0];
			pend_act_q <= sel_act;
		end

		if (wr_fire) begin
			row_index_q     <= 3'd0;
			action_select_q <= edmm_pkg::ACT_NONE;
			readback_data_q <= in_range ? write_data : ~write_data;
			last_result_q   <= 1'b1;
		end else if (final_fire) begin
			row_index_q     <= pend_v_q ? pend_row_q : 3'd0;
			action_select_q <= pend_v_q ? pend_act_q : edmm_pkg::ACT_NONE;
			readback_data_q <= 8'd0;
			last_result_q   <= 1'b1;
		end else if (push_pend) begin
			// a newer match exists, so the held one is not the last
			row_index_q     <= pend_row_q;
			action_select_q <= pend_act_q;
			readback_data_q <= 8'd0;
			last_result_q   <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign row_index     = row_index_q;
	assign action_select = action_select_q;
	assign readback_data = readback_data_q;
	assign last_result   = last_result_q;

	a_tok_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok))
		else $error("more than one walk token");

	a_walk_tok: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WALK) |-> $onehot(tok))
		else $error("walk without exactly one token");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= edmm_pkg::OUT_CNT_W'(edmm_pkg::MAX_OUT))
		else $error("result count beyond limit");

	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (st_q != ST_IDLE))
		else $error("pending result left over in idle");

	a_start_walk: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ((st_q == ST_WALK) && tok[0]))
		else $error("event start did not seed the first cell");

endmodule

@@ tb/decision_match_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decision_match_checker
// Watches the configuration port and both channels of the decision matrix
// matcher. Keeps its own copy of the table and registers, works out the
// results of every input transfer and compares each output transfer with the
// oldest outstanding result, field by field.
// ----------------------------------------------------------------------------
module decision_match_checker
	import edmm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 operation,
	input  logic [ADDR_W-1:0]    table_address,
	input  logic [7:0]           write_data,
	input  logic [8:0]           event_class,
	input  logic [7:0]           event_type,
	input  logic [7:0]           origin_address,
	input  logic [7:0]           event_zone,
	input  logic [7:0]           event_subzone,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [2:0]           row_index,
	input  logic [1:0]           action_select,
	input  logic [7:0]           readback_data,
	input  logic                 last_result,
	output int                   outstanding,
	output int                   failures
);

	typedef struct packed {
		logic [2:0] row_idx;
		logic [1:0] act_sel;
		logic [7:0] readback;
		logic       last;
	} match_result_t;

	logic [7:0]    matrix_bytes [TABLE_SIZE];
	logic [7:0]    zone_reg;
	logic [7:0]    subzone_reg;
	logic [7:0]    code_one;
	logic [7:0]    code_two;
	match_result_t pending_results [$];

	task automatic predict_matches();
		match_result_t prev;
		match_result_t res;
		logic          have_prev;
		logic [7:0]    flags;
		logic [7:0]    act;
		logic [8:0]    cmask;
		logic [8:0]    cfilt;
		int            base;
		int            found;
		have_prev = 1'b0;
		found = 0;
		res = '0;
		if (operation == OP_WRITE) begin
			if (table_address < TABLE_SIZE) begin
				matrix_bytes[table_address] = write_data;
				res.readback = matrix_bytes[table_address];
			end else begin
				// error code for an address past the table
				res.readback = ~write_data;
			end
			res.last = 1'b1;
			pending_results.push_back(res);
			return;
		end
		if (event_class != PROTOCOL_CLASS) begin
			for (int r = 0; r < ROWS && found < MAX_OUT; r++) begin
				base = r * ROW_BYTES;
				flags = matrix_bytes[base + BYTE_FLAGS];
				cmask = {flags[FLAG_MASK_B8], matrix_bytes[base + BYTE_CMASK]};
				cfilt = {flags[FLAG_FILT_B8], matrix_bytes[base + BYTE_CFILT]};
				act = matrix_bytes[base + BYTE_ACTION];
				if (!flags[FLAG_ENABLED])
					continue;
				if (flags[FLAG_ORIGIN] && origin_address != matrix_bytes[base + BYTE_ORIGIN])
					continue;
				if (flags[FLAG_ZONE] && event_zone != zone_reg)
					continue;
				if (flags[FLAG_SUBZONE] && event_subzone != subzone_reg)
					continue;
				if (((cfilt ^ event_class) & cmask) != '0)
					continue;
				if (((matrix_bytes[base + BYTE_TFILT] ^ event_type) &
				     matrix_bytes[base + BYTE_TMASK]) != '0)
					continue;
				if (act != code_one && act != code_two)
					continue;
				// hold each hit back one step so the final one can carry last
				if (have_prev)
					pending_results.push_back(prev);
				prev = '0;
				prev.row_idx = 3'(r);
				prev.act_sel = (act == code_one) ? ACT_ONE : ACT_TWO;
				have_prev = 1'b1;
				found++;
			end
		end
		if (have_prev) begin
			prev.last = 1'b1;
			pending_results.push_back(prev);
		end else begin
			res.last = 1'b1;
			pending_results.push_back(res);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
	                           input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		match_result_t want;
		if (!arst_n) begin
			foreach (matrix_bytes[i])
				matrix_bytes[i] = '0;
			zone_reg = '0;
			subzone_reg = '0;
			code_one = ACT_ONE_RESET;
			code_two = ACT_TWO_RESET;
			pending_results.delete();
			failures = 0;
			outstanding <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_NODE_ZONE: zone_reg = cfg_data;
					REG_NODE_SUBZONE: subzone_reg = cfg_data;
					REG_ACT_ONE: code_one = cfg_data;
					REG_ACT_TWO: code_two = cfg_data;
				endcase
			end
			if (in_valid && in_ready)
				predict_matches();
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t ns: result with none expected: row %0d act %0d data %0d last %0b",
					         $time, row_index, action_select, readback_data, last_result);
					failures++;
				end else begin
					want = pending_results.pop_front();
					check_field("row_index", 8'(want.row_idx), 8'(row_index));
					check_field("action_select", 8'(want.act_sel), 8'(action_select));
					check_field("readback_data", want.readback, readback_data);
					check_field("last_result", 8'(want.last), 8'(last_result));
				end
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

@@ tb/event_decision_matrix_matcher_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_decision_matrix_matcher_tb
// Drives table writes, events and register settings into the matcher under
// random valid/ready pressure; a checker beside the block predicts and
// compares every result and the top gives the verdict.
// ----------------------------------------------------------------------------
module event_decision_matrix_matcher_tb;
	import edmm_pkg::*;

	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [7:0] EN_BIT      = 8'(1 << FLAG_ENABLED);
	localparam logic [7:0] ORIGIN_BIT  = 8'(1 << FLAG_ORIGIN);
	localparam logic [7:0] ZONE_BIT    = 8'(1 << FLAG_ZONE);
	localparam logic [7:0] SUBZONE_BIT = 8'(1 << FLAG_SUBZONE);
	localparam logic [7:0] MASK8_BIT   = 8'(1 << FLAG_MASK_B8);
	localparam logic [7:0] FILT8_BIT   = 8'(1 << FLAG_FILT_B8);
	// flag bits with no meaning to the matcher
	localparam logic [7:0] SPARE_BITS  = 8'h24;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 operation = OP_WRITE;
	logic [ADDR_W-1:0]    table_address = '0;
	logic [7:0]           write_data = '0;
	logic [8:0]           event_class = '0;
	logic [7:0]           event_type = '0;
	logic [7:0]           origin_address = '0;
	logic [7:0]           event_zone = '0;
	logic [7:0]           event_subzone = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [2:0]           row_index;
	logic [1:0]           action_select;
	logic [7:0]           readback_data;
	logic                 last_result;

	int         outstanding;
	int         failures;
	int         send_idle_pct = 22;
	int         recv_idle_pct = 82;
	int         items_sent = 0;
	int         stalled_cycles = 0;
	logic [7:0] written [TABLE_SIZE];
	logic [7:0] zone_cfg = '0;
	logic [7:0] subzone_cfg = '0;
	logic [7:0] code_one_cfg = ACT_ONE_RESET;
	logic [7:0] code_two_cfg = ACT_TWO_RESET;

	event_decision_matrix_matcher uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .table_address(table_address), .write_data(write_data),
		.event_class(event_class), .event_type(event_type),
		.origin_address(origin_address), .event_zone(event_zone),
		.event_subzone(event_subzone),
		.out_valid(out_valid), .out_ready(out_ready),
		.row_index(row_index), .action_select(action_select),
		.readback_data(readback_data), .last_result(last_result)
	);

	decision_match_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .table_address(table_address), .write_data(write_data),
		.event_class(event_class), .event_type(event_type),
		.origin_address(origin_address), .event_zone(event_zone),
		.event_subzone(event_subzone),
		.out_valid(out_valid), .out_ready(out_ready),
		.row_index(row_index), .action_select(action_select),
		.readback_data(readback_data), .last_result(last_result),
		.outstanding(outstanding), .failures(failures)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stalled_cycles <= 0;
			end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				stalled_cycles <= stalled_cycles + 1;
			end
		end
	end

	task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
	                         input logic [7:0] data, input logic [8:0] cls,
	                         input logic [7:0] typ, input logic [7:0] org,
	                         input logic [7:0] zn, input logic [7:0] szn);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		operation <= op;
		table_address <= addr;
		write_data <= data;
		event_class <= cls;
		event_type <= typ;
		origin_address <= org;
		event_zone <= zn;
		event_subzone <= szn;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// the non-write fields carry random noise that the block must ignore
	task automatic send_write(input int addr, input logic [7:0] data);
		written[addr] = data;
		send_item(OP_WRITE, ADDR_W'(addr), data, 9'($urandom), 8'($urandom),
		          8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic send_event(input logic [8:0] cls, input logic [7:0] typ,
	                          input logic [7:0] org, input logic [7:0] zn,
	                          input logic [7:0] szn);
		send_item(OP_EVENT, ADDR_W'($urandom), 8'($urandom), cls, typ, org, zn, szn);
	endtask

	task automatic program_config(input logic [7:0] zn, input logic [7:0] szn,
	                              input logic [7:0] one, input logic [7:0] two);
		logic [7:0] vals [4];
		vals = '{zn, szn, one, two};
		for (int i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		zone_cfg = zn;
		subzone_cfg = szn;
		code_one_cfg = one;
		code_two_cfg = two;
	endtask

	// let every outstanding result drain and the block go idle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_action();
		int sel;
		sel = $urandom_range(9);
		if (sel < 4)
			return code_one_cfg;
		else if (sel < 8)
			return code_two_cfg;
		return 8'($urandom);
	endfunction

	task automatic write_random_row(input int row);
		int         base;
		logic [7:0] flags;
		base = row * ROW_BYTES;
		flags = 8'($urandom);
		flags[FLAG_ENABLED] = ($urandom_range(4) != 0);
		send_write(base + BYTE_ORIGIN, 8'($urandom));
		send_write(base + BYTE_FLAGS, flags);
		send_write(base + BYTE_CMASK, ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom));
		send_write(base + BYTE_CFILT, 8'($urandom));
		send_write(base + BYTE_TMASK, ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom));
		send_write(base + BYTE_TFILT, 8'($urandom));
		send_write(base + BYTE_ACTION, pick_action());
		send_write(base + ROW_BYTES - 1, 8'($urandom));
	endtask

	// build an event that passes the row's compares most of the time
	task automatic send_matching_event(input int row);
		int         base;
		logic [7:0] flags;
		logic [8:0] mask9;
		logic [8:0] filt9;
		logic [7:0] tmask;
		base = row * ROW_BYTES;
		flags = written[base + BYTE_FLAGS];
		mask9 = {flags[FLAG_MASK_B8], written[base + BYTE_CMASK]};
		filt9 = {flags[FLAG_FILT_B8], written[base + BYTE_CFILT]};
		tmask = written[base + BYTE_TMASK];
		send_event((filt9 & mask9) | (9'($urandom) & ~mask9),
		           (written[base + BYTE_TFILT] & tmask) | (8'($urandom) & ~tmask),
		           ($urandom_range(5) != 0) ? written[base + BYTE_ORIGIN] : 8'($urandom),
		           ($urandom_range(5) != 0) ? zone_cfg : 8'($urandom),
		           ($urandom_range(5) != 0) ? subzone_cfg : 8'($urandom));
	endtask

	task automatic random_traffic(input int goal);
		int sel;
		while (items_sent < goal) begin
			sel = $urandom_range(99);
			if (sel < 15)
				write_random_row($urandom_range(ROWS - 1));
			else if (sel < 25)
				send_write($urandom_range(TABLE_SIZE - 1), 8'($urandom));
			else if (sel < 80)
				send_matching_event($urandom_range(ROWS - 1));
			else
				send_event(($urandom_range(4) == 0) ? PROTOCOL_CLASS : 9'($urandom),
				           8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		foreach (written[i])
			written[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, reset register values
		send_event(PROTOCOL_CLASS, 8'h00, 8'h00, 8'h00, 8'h00);
		send_event(9'h1FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_write(0 * ROW_BYTES + BYTE_FLAGS, EN_BIT);
		send_write(0 * ROW_BYTES + BYTE_ACTION, ACT_ONE_RESET);
		send_event(9'h001, 8'h00, 8'h00, 8'h00, 8'h00);
		send_event(PROTOCOL_CLASS, 8'h00, 8'h00, 8'h00, 8'h00);
		// row 7 uses every check, including the ninth class bit
		send_write(7 * ROW_BYTES + BYTE_ORIGIN, 8'hAB);
		send_write(7 * ROW_BYTES + BYTE_FLAGS,
		           EN_BIT | ORIGIN_BIT | ZONE_BIT | SUBZONE_BIT | MASK8_BIT | FILT8_BIT);
		send_write(7 * ROW_BYTES + BYTE_CMASK, 8'hFF);
		send_write(7 * ROW_BYTES + BYTE_TMASK, 8'hF0);
		send_write(7 * ROW_BYTES + BYTE_TFILT, 8'hA0);
		send_write(7 * ROW_BYTES + BYTE_ACTION, ACT_TWO_RESET);
		send_write(7 * ROW_BYTES + ROW_BYTES - 1, 8'hFF);
		send_event(9'h100, 8'hA5, 8'hAB, 8'h00, 8'h00);
		send_event(9'h100, 8'hA5, 8'hAA, 8'h00, 8'h00);
		send_event(9'h100, 8'hA5, 8'hAB, 8'h01, 8'h00);
		send_event(9'h100, 8'hA5, 8'hAB, 8'h00, 8'h01);
		send_event(9'h101, 8'hA5, 8'hAB, 8'h00, 8'h00);
		send_event(9'h100, 8'hB5, 8'hAB, 8'h00, 8'h00);
		// row 3 matches everything but carries an unknown action
		send_write(3 * ROW_BYTES + BYTE_FLAGS, EN_BIT);
		send_write(3 * ROW_BYTES + BYTE_ACTION, 8'h77);
		send_write(7 * ROW_BYTES + ROW_BYTES - 1, 8'h00);
		send_write(0 * ROW_BYTES + BYTE_FLAGS, 8'h00);
		send_event(9'h100, 8'hA5, 8'hAB, 8'h00, 8'h00);
		send_event(9'h055, 8'h12, 8'h34, 8'h56, 8'h78);
		settle();

		// extreme register values; every row matches at first
		program_config(8'hFF, 8'h00, 8'hFF, 8'h00);
		for (int r = 0; r < ROWS; r++) begin
			send_write(r * ROW_BYTES + BYTE_ORIGIN, 8'($urandom));
			send_write(r * ROW_BYTES + BYTE_FLAGS, EN_BIT | (8'($urandom) & SPARE_BITS));
			send_write(r * ROW_BYTES + BYTE_CMASK, 8'h00);
			send_write(r * ROW_BYTES + BYTE_CFILT, 8'($urandom));
			send_write(r * ROW_BYTES + BYTE_TMASK, 8'h00);
			send_write(r * ROW_BYTES + BYTE_TFILT, 8'($urandom));
			send_write(r * ROW_BYTES + BYTE_ACTION,
			           $urandom_range(1) ? code_one_cfg : code_two_cfg);
			send_write(r * ROW_BYTES + ROW_BYTES - 1, 8'($urandom));
		end
		random_traffic(220);
		settle();

		// equal action codes, idling swapped
		send_idle_pct = 82;
		recv_idle_pct <= 22;
		program_config(8'h00, 8'hFF, 8'h33, 8'h33);
		random_traffic(345);
		settle();

		// random registers, no idling
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		program_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		random_traffic(470);
		settle();

		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ event_decision_matrix_matcher.f @@
design/edmm_pkg.sv
design/edmm_cell.sv
design/event_decision_matrix_matcher.sv
tb/decision_match_checker.sv
tb/event_decision_matrix_matcher_tb.sv
